### src/mie_pkg.sv
// shared types and constants for the modular inverse block
// no dependencies; used by mie_divstep and modular_inverse_ext_euclid
package mie_pkg;

  localparam int unsigned OperandWidth = 31;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StDiv,
    StUpd,
    StFix1,
    StFix2
  } state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### src/mie_divstep.sv
// one euclid step: restoring division r / r' one quotient bit per cycle,
// with the quotient times the next coefficient accumulated alongside; uses mie_pkg
module mie_divstep #(
  parameter int unsigned W = mie_pkg::OperandWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mie_pkg::div_ctrl_t    ctrl_i,
  input  logic [W-1:0]          dividend_i,
  input  logic [W-1:0]          divisor_i,
  input  logic [W+1:0]          coef_i,
  output logic [W+1:0]          quot_coef_o,
  output logic [W-1:0]          rem_o,
  output mie_pkg::div_stat_t    stat_o
);

  localparam int unsigned CW   = W + 2;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    d_q, d_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [CW-1:0]   p_q, p_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [W:0]      shifted;
  logic [W:0]      diff;
  logic            ge;

  assign shifted = {rem_q, d_q[W-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign ge      = shifted >= {1'b0, divisor_i};

  always_comb begin
    d_d    = d_q;
    rem_d  = rem_q;
    p_d    = p_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      d_d    = dividend_i;
      rem_d  = '0;
      p_d    = '0;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      d_d   = {d_q[W-2:0], 1'b0};
      rem_d = ge ? diff[W-1:0] : shifted[W-1:0];
      // horner form: quotient bits arrive msb first
      p_d   = {p_q[CW-2:0], 1'b0} + (ge ? coef_i : '0);
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    rem_q <= rem_d;
    p_q   <= p_d;
  end

  assign quot_coef_o = p_q;
  assign rem_o       = rem_q;
  assign stat_o      = '{busy: busy_q, done: done_q};

endmodule

### src/modular_inverse_ext_euclid.sv
// Modular inverse of value modulo modulus by the extended Euclidean algorithm.
// One item at a time: after a transfer in, each Euclid step is a check, a
// bit-serial restoring division in mie_divstep and an update, and up to about
// 46 steps occur for 31-bit operands. A finished result sits in an output
// register, so the next item may be transferred in while it waits.
// no_inverse_o is set, with inverse_o zero, when the gcd exceeds 1.
// depends on mie_pkg and mie_divstep
module modular_inverse_ext_euclid #(
  parameter int unsigned OPERAND_WIDTH = mie_pkg::OperandWidth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OPERAND_WIDTH-1:0] value_i,
  input  logic [OPERAND_WIDTH-1:0] modulus_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [OPERAND_WIDTH-1:0] inverse_o,
  output logic                     no_inverse_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = W + 2;

  mie_pkg::state_e    state_q, state_d;
  mie_pkg::div_ctrl_t div_ctrl;
  mie_pkg::div_stat_t div_stat;

  logic [W-1:0]  r_q, r_d, rn_q, rn_d, mod_q, mod_d;
  logic [CW-1:0] t_q, t_d, tn_q, tn_d;
  logic [CW-1:0] qc;
  logic [W-1:0]  rem;

  logic          out_valid_q, out_valid_d;
  logic [W-1:0]  inv_q, inv_d;
  logic          none_q, none_d;

  logic          accept_in;
  logic          out_load;
  logic          sub_mod;
  logic [CW-1:0] t_fin;
  logic          gcd_gt1;

  mie_divstep #(
    .W (W)
  ) u_divstep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl),
    .dividend_i  (r_q),
    .divisor_i   (rn_q),
    .coef_i      (tn_q),
    .quot_coef_o (qc),
    .rem_o       (rem),
    .stat_o      (div_stat)
  );

  assign accept_in = in_valid_i && in_ready_o;
  assign gcd_gt1   = r_q[W-1:1] != '0;
  // compare is unsigned in the wide word, so a negative value counts as large
  assign sub_mod   = (mod_q != '0) && (t_q[CW-1] || (t_q >= {2'b00, mod_q}));
  assign t_fin     = sub_mod ? t_q - {2'b00, mod_q} : t_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mie_pkg::StIdle:  if (in_valid_i) state_d = mie_pkg::StCheck;
      mie_pkg::StCheck: state_d = (rn_q != '0) ? mie_pkg::StDiv : mie_pkg::StFix1;
      mie_pkg::StDiv:   if (div_stat.done) state_d = mie_pkg::StUpd;
      mie_pkg::StUpd:   state_d = mie_pkg::StCheck;
      mie_pkg::StFix1:  state_d = mie_pkg::StFix2;
      mie_pkg::StFix2:  if (!out_valid_q || out_ready_i) state_d = mie_pkg::StIdle;
      default:          state_d = mie_pkg::StIdle;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o     = 1'b0;
    div_ctrl.start = 1'b0;
    out_load       = 1'b0;
    unique case (state_q)
      mie_pkg::StIdle:  in_ready_o = 1'b1;
      mie_pkg::StCheck: div_ctrl.start = rn_q != '0;
      mie_pkg::StFix2:  out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    r_d   = r_q;
    rn_d  = rn_q;
    t_d   = t_q;
    tn_d  = tn_q;
    mod_d = mod_q;
    if (accept_in) begin
      r_d   = modulus_i;
      rn_d  = value_i;
      t_d   = '0;
      tn_d  = CW'(1);
      mod_d = modulus_i;
    end else if (state_q == mie_pkg::StUpd) begin
      r_d  = rn_q;
      rn_d = rem;
      t_d  = tn_q;
      tn_d = t_q - qc;
    end else if (state_q == mie_pkg::StFix1 && t_q[CW-1]) begin
      t_d = t_q + {2'b00, mod_q};
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    inv_d       = inv_q;
    none_d      = none_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (out_load) begin
      out_valid_d = 1'b1;
      none_d      = gcd_gt1;
      inv_d       = gcd_gt1 ? '0 : t_fin[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mie_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    rn_q   <= rn_d;
    t_q    <= t_d;
    tn_q   <= tn_d;
    mod_q  <= mod_d;
    inv_q  <= inv_d;
    none_q <= none_d;
  end

  assign out_valid_o  = out_valid_q;
  assign inverse_o    = inv_q;
  assign no_inverse_o = none_q;

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mie_pkg::StDiv |-> rn_q != '0)
    else $error("division running with zero divisor");

  a_upd_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mie_pkg::StUpd |-> $past(div_stat.done))
    else $error("coefficient update without finished division");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_inverse_o |-> inverse_o == '0)
    else $error("inverse not zero when none exists");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == mie_pkg::StCheck && !div_stat.busy)
    else $error("transfer in did not start a new item");
`endif

endmodule
